>>> rtl/assert_macros.svh
// Assertion macros shared by the route table RTL.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dvrt_pkg.sv
// Package for the distance-vector route table: sizes, codes, payload types.
// Used by dvrt_match, the top level and the checker; depends on nothing.
package dvrt_pkg;

   localparam int unsigned TABLE_DEPTH  = 32;
   localparam int unsigned PORT_COUNT   = 4;
   localparam int unsigned INDEX_WIDTH  = $clog2(TABLE_DEPTH);
   localparam int unsigned METRIC_WIDTH = 5;
   localparam int unsigned LENGTH_WIDTH = 6;

   localparam logic [METRIC_WIDTH-1:0] INFINITY_METRIC = 5'd16;

   // Command codes
   localparam logic [1:0] CMD_APPLY   = 2'd0;
   localparam logic [1:0] CMD_DUMP    = 2'd1;
   localparam logic [1:0] CMD_INSTALL = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_IGNORED    = 3'd0;
   localparam logic [2:0] ST_INSERTED   = 3'd1;
   localparam logic [2:0] ST_UPDATED    = 3'd2;
   localparam logic [2:0] ST_ERASED     = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_DUMP_ENTRY = 3'd5;
   localparam logic [2:0] ST_DUMP_EMPTY = 3'd6;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] route_addr;
      logic [31:0] route_mask;
      logic [31:0] route_nexthop;
      logic [31:0] route_metric;
      logic [31:0] sender_addr;
      logic [1:0]  port_index;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [31:0]             out_addr;
      logic [31:0]             out_mask;
      logic [31:0]             out_nexthop;
      logic [METRIC_WIDTH-1:0] out_metric;
      logic                    last;
   } rsp_type;

   // One table slot as held in the route memory
   typedef struct packed {
      logic [31:0]             prefix;
      logic [LENGTH_WIDTH-1:0] length;
      logic [31:0]             gateway;
      logic [METRIC_WIDTH-1:0] cost;
      logic [1:0]              port;
   } slot_type;

   // Sequencer to match unit
   typedef struct packed {
      logic                   start;
      logic                   issue;
      logic [INDEX_WIDTH-1:0] issue_idx;
   } scan_ctl_type;

   // Match unit to sequencer
   typedef struct packed {
      logic                    found;
      logic [INDEX_WIDTH-1:0]  match_idx;
      logic [METRIC_WIDTH-1:0] match_cost;
      logic [31:0]             match_gateway;
      logic                    free_found;
      logic [INDEX_WIDTH-1:0]  free_idx;
   } scan_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_RESULT,
      S_DUMP_SEEK,
      S_DUMP_EMIT
   } state_type;

   // Mask with the top len bits set
   function automatic logic [31:0] len_to_mask(input logic [LENGTH_WIDTH-1:0] len);
      logic [31:0] mask;
      if (len >= LENGTH_WIDTH'(32)) begin
         mask = 32'hFFFF_FFFF;
      end else begin
         mask = ~(32'hFFFF_FFFF >> len[4:0]);
      end
      return mask;
   endfunction

endpackage

>>> rtl/dvrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module dvrt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/dvrt_match.sv
// Shared slot compare unit: checks one slot per cycle against the key and
// tracks the first matching slot and the first free slot. Uses dvrt_pkg.
module dvrt_match (
   input  logic                                      clock,
   input  logic                                      reset,
   input  dvrt_pkg::scan_ctl_type                    ctl,
   input  logic [dvrt_pkg::TABLE_DEPTH-1:0]          slot_valid,
   input  logic [31:0]                               key_prefix,
   input  logic [dvrt_pkg::LENGTH_WIDTH-1:0]         key_length,
   input  dvrt_pkg::slot_type                        rd_slot,
   output dvrt_pkg::scan_result_type                 result
);

   logic                             step_en_ff, step_en_in;
   logic [dvrt_pkg::INDEX_WIDTH-1:0] step_idx_ff, step_idx_in;
   dvrt_pkg::scan_result_type        res_ff, res_in;
   logic                             hit;
   logic                             free;

   // Compare the slot whose read data arrives this cycle
   always_comb begin
      hit  = slot_valid[step_idx_ff] && (rd_slot.prefix == key_prefix) &&
             (rd_slot.length == key_length);
      free = !slot_valid[step_idx_ff];
   end

   // Next value of the tracking registers
   always_comb begin
      step_en_in  = ctl.issue;
      step_idx_in = ctl.issue_idx;
      res_in      = res_ff;
      if (ctl.start) begin
         res_in.found      = 1'b0;
         res_in.free_found = 1'b0;
      end else if (step_en_ff) begin
         if (hit && !res_ff.found) begin
            res_in.found         = 1'b1;
            res_in.match_idx     = step_idx_ff;
            res_in.match_cost    = rd_slot.cost;
            res_in.match_gateway = rd_slot.gateway;
         end
         if (free && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = step_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_en_ff        <= 1'b0;
         res_ff.found      <= 1'b0;
         res_ff.free_found <= 1'b0;
      end else begin
         step_en_ff        <= step_en_in;
         res_ff.found      <= res_in.found;
         res_ff.free_found <= res_in.free_found;
      end
      step_idx_ff          <= step_idx_in;
      res_ff.match_idx     <= res_in.match_idx;
      res_ff.match_cost    <= res_in.match_cost;
      res_ff.match_gateway <= res_in.match_gateway;
      res_ff.free_idx      <= res_in.free_idx;
   end

   assign result = res_ff;

endmodule

>>> rtl/distance_vector_route_table_unit.sv
// Top level of the distance-vector route table: sequencer, valid bits,
// output register. Uses dvrt_pkg, dvrt_ram, dvrt_match and assert_macros.svh.
//
// Usage:
//   Requests enter on req_valid/req_ready with a req_type payload; results
//   leave on rsp_valid/rsp_ready with a rsp_type payload. req_ready is high
//   only while the sequencer is idle, so one request is worked at a time.
//   Apply and install read every slot through the single route memory read
//   port, one slot per cycle, and the shared compare unit checks each one;
//   the sequencer then passes through drain and decide states before it
//   forms the single result. A bad interface or the unused command skips
//   the scan and goes straight to the result.
//   Dump walks the valid bits one slot per cycle while it finds empty
//   slots and, for each valid slot, does a memory read in a seek state and
//   then emits the result; its final result carries last = 1. An empty
//   table answers with one dump-empty result.
//   Results sit in an output register: a new request is taken while the
//   previous result still waits. When the receiver stalls, a dump pauses
//   with its current entry until the register drains.
//   Reset clears the valid bits, so the table is empty at once;
//   the route memory itself is not cleared.
`include "assert_macros.svh"

module distance_vector_route_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dvrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dvrt_pkg::rsp_type rsp_data
);

   localparam int unsigned IW = dvrt_pkg::INDEX_WIDTH;
   localparam int unsigned MW = dvrt_pkg::METRIC_WIDTH;
   localparam int unsigned LW = dvrt_pkg::LENGTH_WIDTH;

   dvrt_pkg::state_type              state_ff, state_in;
   dvrt_pkg::req_type                req_ff, req_in;
   logic [LW-1:0]                    len_ff, len_in;
   logic [MW-1:0]                    metric_ff, metric_in;
   logic [31:0]                      gw_ff, gw_in;
   logic [2:0]                       status_ff, status_in;
   logic [IW-1:0]                    idx_ff, idx_in;
   logic [dvrt_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dvrt_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   dvrt_pkg::scan_ctl_type           scan_ctl;
   dvrt_pkg::scan_result_type        scan_res;
   dvrt_pkg::slot_type               rd_slot;
   dvrt_pkg::slot_type               wr_slot;
   logic [$bits(dvrt_pkg::slot_type)-1:0] rd_bits;

   logic                             port_ok;
   logic                             idx_last;
   logic                             out_free;
   logic                             no_more;
   logic [dvrt_pkg::TABLE_DEPTH-1:0] above;
   logic                             change;
   logic [2:0]                       dec_status;
   logic                             dec_write;
   logic                             dec_erase;
   logic [IW-1:0]                    dec_idx;
   logic                             load_rsp;
   logic                             load_req;
   logic                             ram_we;

   logic                             chk_emit;
   logic                             chk_insert;
   logic                             chk_modify;
   logic                             chk_seek_hit;

   // Route memory and compare unit
   dvrt_ram #(
      .WIDTH ($bits(dvrt_pkg::slot_type)),
      .DEPTH (dvrt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dec_idx),
      .wr_data (wr_slot),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   assign rd_slot = dvrt_pkg::slot_type'(rd_bits);

   dvrt_match u_match (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .slot_valid (valid_ff),
      .key_prefix (req_ff.route_addr),
      .key_length (len_ff),
      .rd_slot    (rd_slot),
      .result     (scan_res)
   );

   // Common conditions
   always_comb begin
      port_ok  = 32'(req_ff.port_index) < dvrt_pkg::PORT_COUNT;
      idx_last = idx_ff == IW'(dvrt_pkg::TABLE_DEPTH - 1);
      out_free = !rsp_valid_ff || rsp_ready;
      for (int k = 0; k < dvrt_pkg::TABLE_DEPTH; k++) begin
         above[k] = IW'(k) > idx_ff;
      end
      no_more = (valid_ff & above) == '0;
   end

   // Apply / install decision once the scan is complete
   always_comb begin
      change     = ((req_ff.sender_addr == scan_res.match_gateway) &&
                    (metric_ff != scan_res.match_cost)) ||
                   (metric_ff < scan_res.match_cost);
      dec_status = dvrt_pkg::ST_IGNORED;
      dec_write  = 1'b0;
      dec_erase  = 1'b0;
      dec_idx    = scan_res.match_idx;
      if (req_ff.cmd == dvrt_pkg::CMD_APPLY) begin
         if (scan_res.found) begin
            if (change && (metric_ff == dvrt_pkg::INFINITY_METRIC)) begin
               dec_erase  = 1'b1;
               dec_status = dvrt_pkg::ST_ERASED;
            end else if (change) begin
               dec_write  = 1'b1;
               dec_status = dvrt_pkg::ST_UPDATED;
            end
         end else if (metric_ff != dvrt_pkg::INFINITY_METRIC) begin
            if (scan_res.free_found) begin
               dec_write  = 1'b1;
               dec_idx    = scan_res.free_idx;
               dec_status = dvrt_pkg::ST_INSERTED;
            end else begin
               dec_status = dvrt_pkg::ST_FULL;
            end
         end
      end else begin
         if (scan_res.found) begin
            dec_write  = 1'b1;
            dec_status = dvrt_pkg::ST_UPDATED;
         end else if (scan_res.free_found) begin
            dec_write  = 1'b1;
            dec_idx    = scan_res.free_idx;
            dec_status = dvrt_pkg::ST_INSERTED;
         end else begin
            dec_status = dvrt_pkg::ST_FULL;
         end
      end
      wr_slot.prefix  = req_ff.route_addr;
      wr_slot.length  = len_ff;
      wr_slot.gateway = gw_ff;
      wr_slot.cost    = metric_ff;
      wr_slot.port    = req_ff.port_index;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvrt_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = dvrt_pkg::S_PREP;
            end
         end
         dvrt_pkg::S_PREP: begin
            if (!port_ok) begin
               state_in = dvrt_pkg::S_RESULT;
            end else begin
               unique case (req_ff.cmd) inside
                  dvrt_pkg::CMD_DUMP: begin
                     state_in = (valid_ff == '0) ? dvrt_pkg::S_RESULT
                                                 : dvrt_pkg::S_DUMP_SEEK;
                  end
                  dvrt_pkg::CMD_APPLY, dvrt_pkg::CMD_INSTALL: begin
                     state_in = dvrt_pkg::S_SCAN;
                  end
                  default: begin
                     state_in = dvrt_pkg::S_RESULT;
                  end
               endcase
            end
         end
         dvrt_pkg::S_SCAN: begin
            if (idx_last) begin
               state_in = dvrt_pkg::S_DRAIN;
            end
         end
         dvrt_pkg::S_DRAIN: begin
            state_in = dvrt_pkg::S_DECIDE;
         end
         dvrt_pkg::S_DECIDE: begin
            state_in = dvrt_pkg::S_RESULT;
         end
         dvrt_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = dvrt_pkg::S_IDLE;
            end
         end
         dvrt_pkg::S_DUMP_SEEK: begin
            if (valid_ff[idx_ff]) begin
               state_in = dvrt_pkg::S_DUMP_EMIT;
            end
         end
         dvrt_pkg::S_DUMP_EMIT: begin
            if (out_free) begin
               state_in = no_more ? dvrt_pkg::S_IDLE : dvrt_pkg::S_DUMP_SEEK;
            end
         end
         default: begin
            state_in = dvrt_pkg::S_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready          = 1'b0;
      load_req           = 1'b0;
      load_rsp           = 1'b0;
      ram_we             = 1'b0;
      scan_ctl.start     = 1'b0;
      scan_ctl.issue     = 1'b0;
      scan_ctl.issue_idx = idx_ff;
      unique case (state_ff) inside
         dvrt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            load_req  = req_valid;
         end
         dvrt_pkg::S_PREP: begin
            scan_ctl.start = 1'b1;
         end
         dvrt_pkg::S_SCAN: begin
            scan_ctl.issue = 1'b1;
         end
         dvrt_pkg::S_DECIDE: begin
            ram_we = dec_write;
         end
         dvrt_pkg::S_RESULT, dvrt_pkg::S_DUMP_EMIT: begin
            load_rsp = out_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in       = load_req ? req_data : req_ff;
      len_in       = len_ff;
      metric_in    = metric_ff;
      gw_in        = gw_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         dvrt_pkg::S_PREP: begin
            len_in = LW'($countones(req_ff.route_mask));
            idx_in = '0;
            if (req_ff.cmd == dvrt_pkg::CMD_APPLY) begin
               metric_in = (req_ff.route_metric >= 32'(dvrt_pkg::INFINITY_METRIC - 5'd1))
                         ? dvrt_pkg::INFINITY_METRIC
                         : req_ff.route_metric[MW-1:0] + MW'(1);
               gw_in     = (req_ff.route_nexthop == 32'd0) ? req_ff.sender_addr
                                                            : req_ff.route_nexthop;
            end else begin
               metric_in = (req_ff.route_metric >= 32'(dvrt_pkg::INFINITY_METRIC))
                         ? dvrt_pkg::INFINITY_METRIC
                         : req_ff.route_metric[MW-1:0];
               gw_in     = 32'd0;
            end
            status_in = (req_ff.cmd == dvrt_pkg::CMD_DUMP) ? dvrt_pkg::ST_DUMP_EMPTY
                                                           : dvrt_pkg::ST_IGNORED;
         end
         dvrt_pkg::S_SCAN: begin
            idx_in = idx_ff + IW'(1);
         end
         dvrt_pkg::S_DECIDE: begin
            status_in = dec_status;
            if (dec_write) begin
               valid_in[dec_idx] = 1'b1;
            end
            if (dec_erase) begin
               valid_in[dec_idx] = 1'b0;
            end
         end
         dvrt_pkg::S_DUMP_SEEK: begin
            if (!valid_ff[idx_ff]) begin
               idx_in = idx_ff + IW'(1);
            end
         end
         dvrt_pkg::S_DUMP_EMIT: begin
            if (out_free && !no_more) begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase

      // Result register load
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (state_ff == dvrt_pkg::S_DUMP_EMIT) begin
            rsp_data_in.status      = dvrt_pkg::ST_DUMP_ENTRY;
            rsp_data_in.out_addr    = rd_slot.prefix;
            rsp_data_in.out_mask    = dvrt_pkg::len_to_mask(rd_slot.length);
            rsp_data_in.out_nexthop = rd_slot.gateway;
            rsp_data_in.out_metric  = (rd_slot.port == req_ff.port_index)
                                    ? dvrt_pkg::INFINITY_METRIC : rd_slot.cost;
            rsp_data_in.last        = no_more;
         end else begin
            rsp_data_in.status      = status_ff;
            rsp_data_in.out_addr    = 32'd0;
            rsp_data_in.out_mask    = 32'd0;
            rsp_data_in.out_nexthop = 32'd0;
            rsp_data_in.out_metric  = '0;
            rsp_data_in.last        = 1'b1;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvrt_pkg::S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      len_ff      <= len_in;
      metric_ff   <= metric_in;
      gw_ff       <= gw_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Terms for the checks
   always_comb begin
      chk_emit     = state_ff == dvrt_pkg::S_DUMP_EMIT;
      chk_insert   = (state_ff == dvrt_pkg::S_DECIDE) &&
                     (dec_status == dvrt_pkg::ST_INSERTED);
      chk_modify   = (state_ff == dvrt_pkg::S_DECIDE) &&
                     ((dec_status == dvrt_pkg::ST_UPDATED) ||
                      (dec_status == dvrt_pkg::ST_ERASED));
      chk_seek_hit = (state_ff == dvrt_pkg::S_DUMP_SEEK) && valid_ff[idx_ff];
   end

   // Checks
   `ASSERT_IMPLIES(a_no_overwrite, load_rsp && rsp_valid_ff, rsp_ready, "result overwritten")
   `ASSERT_IMPLIES(a_dump_valid, chk_emit, valid_ff[idx_ff], "dump of empty slot")
   `ASSERT_IMPLIES(a_insert_free, chk_insert, !valid_ff[dec_idx], "insert into used slot")
   `ASSERT_IMPLIES(a_update_used, chk_modify, valid_ff[dec_idx], "update of empty slot")
   `ASSERT_NEXT(a_seek_emit, chk_seek_hit, state_ff == dvrt_pkg::S_DUMP_EMIT, "dump seek stalled")

endmodule

>>> dv/route_table_checker.sv
// Route table checker: watches the request and result channels, keeps its own
// copy of the route table and compares each result with the predicted one.
// Depends on dvrt_pkg.
module route_table_checker
   import dvrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_due
);

   // Predicted table contents
   bit       slot_live [TABLE_DEPTH];
   slot_type slot_entry [TABLE_DEPTH];

   // Predicted results not yet seen, oldest first
   rsp_type awaited_results [$];

   initial begin
      mismatch_count = 0;
      results_due    = 0;
   end

   // Single-result answer: status only, last set
   function automatic rsp_type status_result(input logic [2:0] status);
      rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic logic [5:0] ones_in(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int b = 0; b < 32; b++) n += 6'(v[b]);
      return n;
   endfunction

   function automatic int lookup_slot(input logic [31:0] prefix, input logic [5:0] len);
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (slot_live[s] && slot_entry[s].prefix == prefix && slot_entry[s].length == len)
            return s;
      end
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (!slot_live[s]) return s;
      end
      return -1;
   endfunction

   task automatic store_route(input int s, input req_type r, input logic [5:0] len,
                              input logic [31:0] gw, input logic [4:0] cost);
      slot_live[s]          = 1'b1;
      slot_entry[s].prefix  = r.route_addr;
      slot_entry[s].length  = len;
      slot_entry[s].gateway = gw;
      slot_entry[s].cost    = cost;
      slot_entry[s].port    = r.port_index;
   endtask

   // Work out the results of one request and update the predicted table
   task automatic predict_route_request(input req_type r);
      logic [5:0]  len;
      logic [32:0] sum;
      logic [4:0]  metric;
      logic [31:0] gw;
      logic [2:0]  status;
      int          hit, spare, live_total, emitted;
      rsp_type     res;
      len     = ones_in(r.route_mask);
      status  = ST_IGNORED;
      hit     = lookup_slot(r.route_addr, len);
      spare   = first_free_slot();
      emitted = 0;
      if (r.cmd == CMD_DUMP) begin
         live_total = 0;
         if (int'(r.port_index) < PORT_COUNT) begin
            for (int s = 0; s < TABLE_DEPTH; s++) live_total += int'(slot_live[s]);
         end
         // one entry per live slot in slot order, own port poisoned
         for (int s = 0; s < TABLE_DEPTH && live_total > 0; s++) begin
            if (slot_live[s]) begin
               emitted++;
               res.status      = ST_DUMP_ENTRY;
               res.out_addr    = slot_entry[s].prefix;
               res.out_mask    = ~(32'hFFFF_FFFF >> slot_entry[s].length);
               res.out_nexthop = slot_entry[s].gateway;
               res.out_metric  = (slot_entry[s].port == r.port_index) ?
                                 INFINITY_METRIC : slot_entry[s].cost;
               res.last        = (emitted == live_total);
               awaited_results.push_back(res);
            end
         end
         if (live_total == 0) awaited_results.push_back(status_result(ST_DUMP_EMPTY));
      end else if (int'(r.port_index) < PORT_COUNT && r.cmd == CMD_APPLY) begin
         // one hop more, saturating at infinity without wrapping
         sum    = {1'b0, r.route_metric} + 33'd1;
         metric = (sum >= 33'(INFINITY_METRIC)) ? INFINITY_METRIC : sum[4:0];
         gw     = (r.route_nexthop == '0) ? r.sender_addr : r.route_nexthop;
         if (hit >= 0) begin
            if ((r.sender_addr == slot_entry[hit].gateway && metric != slot_entry[hit].cost)
                || metric < slot_entry[hit].cost) begin
               if (metric == INFINITY_METRIC) begin
                  slot_live[hit] = 1'b0;
                  status         = ST_ERASED;
               end else begin
                  store_route(hit, r, len, gw, metric);
                  status = ST_UPDATED;
               end
            end
         end else if (metric != INFINITY_METRIC) begin
            if (spare >= 0) begin
               store_route(spare, r, len, gw, metric);
               status = ST_INSERTED;
            end else begin
               status = ST_FULL;
            end
         end
      end else if (int'(r.port_index) < PORT_COUNT && r.cmd == CMD_INSTALL) begin
         metric = (r.route_metric >= 32'(INFINITY_METRIC)) ? INFINITY_METRIC
                                                            : r.route_metric[4:0];
         if (hit >= 0) begin
            store_route(hit, r, len, '0, metric);
            status = ST_UPDATED;
         end else if (spare >= 0) begin
            store_route(spare, r, len, '0, metric);
            status = ST_INSERTED;
         end else begin
            status = ST_FULL;
         end
      end
      if (r.cmd != CMD_DUMP) awaited_results.push_back(status_result(status));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("result with no request outstanding, status %0d", got.status);
         mismatch_count++;
      end else begin
         want = awaited_results.pop_front();
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("out_addr", want.out_addr, got.out_addr);
         check_field("out_mask", want.out_mask, got.out_mask);
         check_field("out_nexthop", want.out_nexthop, got.out_nexthop);
         check_field("out_metric", 32'(want.out_metric), 32'(got.out_metric));
         check_field("last", 32'(want.last), 32'(got.last));
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TABLE_DEPTH; s++) slot_live[s] = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (req_valid && req_ready) predict_route_request(req_data);
      end
      results_due = awaited_results.size();
   end

endmodule

>>> dv/testbench.sv
// Top of the route table testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict.
// Depends on dvrt_pkg, route_table_checker and distance_vector_route_table_unit.
module testbench;
   import dvrt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 16;
   localparam int POOL_SIZE      = 6;
   localparam int FLOOD_ROUTES   = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatch_count;
   int results_due;
   int quiet_cycles = 0;
   bit idling_on;
   bit hold_off_request;

   // Route keys and neighbours reused so that requests hit existing routes
   logic [31:0] key_addr [POOL_SIZE];
   logic [31:0] key_mask [POOL_SIZE];
   logic [31:0] peer_addr [4];
   logic [31:0] flood_addr [$];
   logic [31:0] flood_mask [$];

   distance_vector_route_table_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   route_table_checker route_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] prefix_mask(input int len);
      return ~(32'hFFFF_FFFF >> len);
   endfunction

   function automatic req_type route_req(input logic [1:0] cmd, input logic [31:0] addr,
                                         input logic [31:0] mask, input logic [31:0] nexthop,
                                         input logic [31:0] metric, input logic [31:0] sender,
                                         input logic [1:0] port);
      req_type r;
      r.cmd           = cmd;
      r.route_addr    = addr;
      r.route_mask    = mask;
      r.route_nexthop = nexthop;
      r.route_metric  = metric;
      r.sender_addr   = sender;
      r.port_index    = port;
      return r;
   endfunction

   // Mostly known keys and neighbours, metrics mostly small with some round infinity
   function automatic req_type random_route_request();
      req_type r;
      int      pick;
      pick  = $urandom_range(0, 19);
      r.cmd = (pick < 12) ? CMD_APPLY : (pick < 15) ? CMD_INSTALL :
              (pick < 19) ? CMD_DUMP : CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
         r.route_addr = $urandom;
         r.route_mask = $urandom;
      end else begin
         pick         = $urandom_range(0, POOL_SIZE - 1);
         r.route_addr = key_addr[pick];
         r.route_mask = key_mask[pick];
      end
      case ($urandom_range(0, 9))
         0, 1, 2:    r.route_nexthop = '0;
         3, 4, 5, 6: r.route_nexthop = peer_addr[$urandom_range(0, 3)];
         default:    r.route_nexthop = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       r.route_metric = $urandom;
         1:       r.route_metric = 32'hFFFF_FFFF - $urandom_range(0, 2);
         2, 3:    r.route_metric = $urandom_range(13, 17);
         default: r.route_metric = $urandom_range(0, 12);
      endcase
      r.sender_addr = ($urandom_range(0, 4) == 0) ? $urandom : peer_addr[$urandom_range(0, 3)];
      r.port_index  = 2'($urandom_range(0, 3));
      return r;
   endfunction

   // Offer one request from a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input req_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
   endtask

   initial begin
      logic [31:0] addr;
      logic [31:0] mask;
      req_valid        = 1'b0;
      req_data         = '0;
      reset            = 1'b1;
      idling_on        = 1'b1;
      hold_off_request = 1'b0;

      key_addr[0] = '0;
      key_mask[0] = '0;
      for (int k = 1; k < POOL_SIZE - 1; k++) begin
         key_addr[k] = $urandom;
         key_mask[k] = prefix_mask($urandom_range(8, 32));
      end
      key_addr[POOL_SIZE-1] = $urandom;
      key_mask[POOL_SIZE-1] = $urandom;
      peer_addr[0] = '0;
      peer_addr[1] = $urandom;
      peer_addr[2] = $urandom;
      peer_addr[3] = 32'hFFFF_FFFF;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty dump, installs at the field extremes, unused command
      send_request(route_req(CMD_DUMP, '0, '0, '0, '0, '0, 2'd0));
      send_request(route_req(CMD_INSTALL, 32'h0A00_0000, 32'hFFFF_FF00, 32'h1, 32'd1, '0, 2'd0));
      send_request(route_req(CMD_INSTALL, '0, '0, '0, '0, '0, 2'd3));
      send_request(route_req(CMD_INSTALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2));
      send_request(route_req(CMD_INSTALL, 32'h0A00_0000, 32'hFFFF_FF00, '0, 32'd2, '0, 2'd1));
      send_request(route_req(CMD_UNUSED, 32'h0A00_0000, 32'hFFFF_FF00, '0, 32'd1, '0, 2'd1));
      // Learned route: zero next hop means the sender, then update rules
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, '0, 32'd3,
                             32'h0A00_0001, 2'd1));
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, '0, 32'hFFFF_FFFF,
                             32'h0A00_0002, 2'd2));
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, '0, 32'd5,
                             32'h0A00_0001, 2'd1));
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, '0, 32'd5,
                             32'h0A00_0001, 2'd1));
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0002, 32'd1,
                             32'h0A00_0002, 2'd2));
      send_request(route_req(CMD_APPLY, 32'hC0A8_0100, 32'hFFFF_FF00, '0, 32'd15,
                             32'h0A00_0002, 2'd2));
      // Unknown route at infinity, with and without wrap of the hop count
      send_request(route_req(CMD_APPLY, 32'hAC10_0000, 32'hFFF0_0000, '0, 32'd15,
                             32'h0A00_0001, 2'd2));
      send_request(route_req(CMD_APPLY, 32'hAC10_0000, 32'hFFF0_0000, '0, 32'hFFFF_FFFF,
                             32'h0A00_0001, 2'd2));
      send_request(route_req(CMD_APPLY, 32'hAC10_0000, 32'hFFF0_0000, 32'h0A00_0009, '0,
                             32'h0A00_0001, 2'd2));
      // Scattered mask with the same count of ones matches the /24 route
      send_request(route_req(CMD_APPLY, 32'h0A00_0000, 32'h00FF_FFFF, '0, '0, '0, 2'd3));
      // Worse metric from the current gateway is still taken
      send_request(route_req(CMD_APPLY, 32'hAC10_0000, 32'hFFF0_0000, '0, 32'd14,
                             32'h0A00_0009, 2'd2));
      send_request(route_req(CMD_DUMP, '0, '0, '0, '0, '0, 2'd0));
      send_request(route_req(CMD_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1));
      send_request(route_req(CMD_DUMP, '0, '0, '0, '0, '0, 2'd2));
      // Gateway withdraws the default route
      send_request(route_req(CMD_APPLY, '0, '0, '0, 32'd15, '0, 2'd3));
      // Route held at infinity: no change, then a real improvement
      send_request(route_req(CMD_APPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'd15,
                             32'h0A00_0005, 2'd0));
      send_request(route_req(CMD_APPLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'd3,
                             32'h0A00_0005, 2'd0));
      send_request(route_req(CMD_DUMP, '0, '0, '0, '0, '0, 2'd3));
      wait_for_results();

      // Long result stall while requests keep coming
      hold_off_request = 1'b1;
      repeat (12) send_request(random_route_request());

      // Fill the table past full, list it, then withdraw what was added
      for (int k = 0; k < FLOOD_ROUTES; k++) begin
         addr = $urandom;
         mask = $urandom_range(0, 1) ? $urandom : prefix_mask($urandom_range(0, 32));
         flood_addr.push_back(addr);
         flood_mask.push_back(mask);
         if (k % 2 == 1) begin
            send_request(route_req(CMD_INSTALL, addr, mask, $urandom, $urandom_range(0, 14),
                                   $urandom, 2'($urandom_range(0, 3))));
         end else begin
            send_request(route_req(CMD_APPLY, addr, mask, '0, $urandom_range(0, 13), '0,
                                   2'($urandom_range(0, 3))));
         end
      end
      send_request(route_req(CMD_DUMP, '0, '0, '0, '0, '0, 2'($urandom_range(0, 3))));
      foreach (flood_addr[k]) begin
         send_request(route_req(CMD_APPLY, flood_addr[k], flood_mask[k], $urandom,
                                $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(15, 300),
                                '0, 2'($urandom_range(0, 3))));
      end

      // Random traffic on known keys
      repeat (150) send_request(random_route_request());

      // Final stretch at full rate
      idling_on = 1'b0;
      repeat (30) send_request(random_route_request());

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/dvrt_pkg.sv
rtl/dvrt_ram.sv
rtl/dvrt_match.sv
rtl/distance_vector_route_table_unit.sv
dv/route_table_checker.sv
dv/testbench.sv
